@@ rtl/u16u8_pkg.sv @@
// Shared types and constants for the UTF-16BE to UTF-8 transcoder.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package u16u8_pkg;

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Code unit ranges and UTF-8 limits
  localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [20:0] SUPP_BASE     = 21'h10000;
  localparam logic [15:0] ONE_BYTE_MAX  = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX  = 16'h07FF;
  localparam logic [7:0]  LEAD2         = 8'hC0;
  localparam logic [7:0]  LEAD3         = 8'hE0;
  localparam logic [7:0]  LEAD4         = 8'hF0;
  localparam logic [1:0]  CONT_TAG      = 2'b10;

  // Error codes carried on the result channel
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_ODD_LEN    = 3'd1,
    ERR_TRUNC_PAIR = 3'd2,
    ERR_BAD_PAIR   = 3'd3,
    ERR_LONE_LOW   = 3'd4
  } err_code_t;

  // Input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } in_item_t;

  // Output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] error_code;
  } out_item_t;

  // One decoded code point (or error) handed from front to back
  typedef struct packed {
    err_code_t   err;
    logic [1:0]  last_idx;   // number of UTF-8 bytes minus one
    logic [20:0] cp;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/u16u8_front.sv @@
// Front end: takes stream bytes, pairs them into code units and surrogates,
// and pushes one job per code point or error. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u16u8_pkg::in_item_t in_data,
  input  u16u8_pkg::q_stat_t  q_stat,
  output logic                job_push,
  output u16u8_pkg::job_t     job
);

  logic       byte_pending_r, byte_pending_nxt;
  logic       surr_pending_r, surr_pending_nxt;
  logic       stream_failed_r, stream_failed_nxt;
  logic [7:0] held_high_byte_r, held_high_byte_nxt;
  logic [9:0] held_surr_r, held_surr_nxt;

  logic        accept;
  logic [15:0] unit;
  logic        is_high;
  logic        is_low;
  logic        at_end;

  assign in_ready = ~q_stat.full;
  assign accept   = in_valid & in_ready;
  assign at_end   = in_data.end_of_data;
  assign unit     = {held_high_byte_r, in_data.in_byte};
  assign is_high  = (unit[15:10] == u16u8_pkg::SURR_HIGH_TAG);
  assign is_low   = (unit[15:10] == u16u8_pkg::SURR_LOW_TAG);

  // Classify the incoming byte against the held state
  always_comb begin
    byte_pending_nxt   = byte_pending_r;
    surr_pending_nxt   = surr_pending_r;
    stream_failed_nxt  = stream_failed_r;
    held_high_byte_nxt = held_high_byte_r;
    held_surr_nxt      = held_surr_r;
    job_push           = 1'b0;
    job                = '0;
    job.err            = u16u8_pkg::ERR_NONE;

    if (accept) begin
      if (stream_failed_r) begin
        // drop until end mark
        if (at_end) begin
          stream_failed_nxt = 1'b0;
          byte_pending_nxt  = 1'b0;
          surr_pending_nxt  = 1'b0;
        end
      end else if (!byte_pending_r) begin
        if (at_end) begin
          job_push         = 1'b1;
          job.err          = u16u8_pkg::ERR_ODD_LEN;
          surr_pending_nxt = 1'b0;
        end else begin
          held_high_byte_nxt = in_data.in_byte;
          byte_pending_nxt   = 1'b1;
        end
      end else begin
        byte_pending_nxt = 1'b0;
        if (surr_pending_r) begin
          surr_pending_nxt = 1'b0;
          job_push         = 1'b1;
          if (!is_low) begin
            job.err           = u16u8_pkg::ERR_BAD_PAIR;
            stream_failed_nxt = ~at_end;
          end else begin
            job.last_idx = 2'd3;
            job.cp       = 21'({held_surr_r, unit[9:0]}) + u16u8_pkg::SUPP_BASE;
          end
        end else if (is_high) begin
          if (at_end) begin
            job_push = 1'b1;
            job.err  = u16u8_pkg::ERR_TRUNC_PAIR;
          end else begin
            held_surr_nxt    = unit[9:0];
            surr_pending_nxt = 1'b1;
          end
        end else if (is_low) begin
          job_push          = 1'b1;
          job.err           = u16u8_pkg::ERR_LONE_LOW;
          stream_failed_nxt = ~at_end;
        end else begin
          // plain BMP code point
          job_push = 1'b1;
          job.cp   = 21'(unit);
          if (unit <= u16u8_pkg::ONE_BYTE_MAX) begin
            job.last_idx = 2'd0;
          end else if (unit <= u16u8_pkg::TWO_BYTE_MAX) begin
            job.last_idx = 2'd1;
          end else begin
            job.last_idx = 2'd2;
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pending_r  <= 1'b0;
      surr_pending_r  <= 1'b0;
      stream_failed_r <= 1'b0;
    end else begin
      byte_pending_r  <= byte_pending_nxt;
      surr_pending_r  <= surr_pending_nxt;
      stream_failed_r <= stream_failed_nxt;
    end
  end

  // Held payload, only read while its pending flag is set
  always_ff @(posedge clk) begin
    held_high_byte_r <= held_high_byte_nxt;
    held_surr_r      <= held_surr_nxt;
  end

endmodule

@@ rtl/u16u8_queue.sv @@
// Small register FIFO of decoded jobs between front and back.
// Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_queue #(
  parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  u16u8_pkg::job_t    push_job,
  input  logic               pop,
  output u16u8_pkg::job_t    head,
  output u16u8_pkg::q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u16u8_pkg::job_t entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push & ~q_stat.full;
  assign do_pop       = pop & ~q_stat.empty;
  assign head         = entries_r[rd_ptr_r];

  // Pointer and count update with wrap at DEPTH
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/u16u8_back.sv @@
// Back end: expands one job into its UTF-8 words, one per cycle unless
// out_ready stalls, into an output register. Depends on u16u8_pkg.
`timescale 1ns / 1ps

module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u16u8_pkg::job_t      head,
  input  u16u8_pkg::q_stat_t   q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_data
);

  u16u8_pkg::job_t     cur_job_r, cur_job_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  u16u8_pkg::out_item_t out_data_r, out_data_nxt;

  logic       cur_adv;
  logic       cur_done;
  logic [1:0] sel;
  logic [5:0] six;
  logic [7:0] byte_val;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cur_adv  = cur_valid_r & (~out_valid_r | out_ready);
  assign cur_done = cur_adv & (idx_r == cur_job_r.last_idx);
  assign pop      = ~q_stat.empty & (~cur_valid_r | cur_done);

  // Six payload bits for a continuation byte
  assign sel = cur_job_r.last_idx - idx_r;
  always_comb begin
    case (sel)
      2'd0:    six = cur_job_r.cp[5:0];
      2'd1:    six = cur_job_r.cp[11:6];
      2'd2:    six = cur_job_r.cp[17:12];
      default: six = {3'b000, cur_job_r.cp[20:18]};
    endcase
  end

  // Lead byte by sequence length, continuation otherwise
  always_comb begin
    if (idx_r == 2'd0) begin
      unique case (cur_job_r.last_idx)
        2'd0: byte_val = cur_job_r.cp[7:0];
        2'd1: byte_val = u16u8_pkg::LEAD2 | {3'b000, cur_job_r.cp[10:6]};
        2'd2: byte_val = u16u8_pkg::LEAD3 | {4'b0000, cur_job_r.cp[15:12]};
        2'd3: byte_val = u16u8_pkg::LEAD4 | {5'b00000, cur_job_r.cp[20:18]};
        default: byte_val = '0;
      endcase
    end else begin
      byte_val = {u16u8_pkg::CONT_TAG, six};
    end
  end

  // Job sequencing and output register
  always_comb begin
    cur_job_nxt   = cur_job_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    if (cur_adv) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.out_byte   = byte_val;
      out_data_nxt.out_last   = (idx_r == cur_job_r.last_idx);
      out_data_nxt.error_code = cur_job_r.err;
      idx_nxt                 = idx_r + 1'b1;
    end
    if (pop) begin
      cur_job_nxt   = head;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_job_r  <= cur_job_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/utf16be_to_utf8_transcoder.sv @@
// UTF-16BE byte stream in, UTF-8 words out; error words flag malformed input.
// Path: the first UTF-8 word of a code point passes the queue write, the job register
// and the output register after its final input byte is accepted.
// Throughput: one input byte per cycle while the job queue has room; one output
// word per cycle from the back-end serializer while out_ready is high, which
// sets the sustained rate.
// Reset: synchronous active-low rst_n clears stream state, queue and output.
`timescale 1ns / 1ps

module utf16be_to_utf8_transcoder #(
  parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16u8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_data
);

  logic               job_push;
  u16u8_pkg::job_t    job;
  u16u8_pkg::job_t    head;
  u16u8_pkg::q_stat_t q_stat;
  logic               pop;

  // Byte pairing and classification
  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (job)
  );

  // Decoupling queue
  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // UTF-8 serializer
  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_utf16be_to_utf8_transcoder.sv @@
// Self-checking testbench for utf16be_to_utf8_transcoder: directed and random UTF-16BE streams.
// A local transcoder model predicts every UTF-8 or error word. Needs rtl/u16u8_pkg.sv and the RTL.
`timescale 1ns / 1ps

module tb_utf16be_to_utf8_transcoder;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned RANDOM_WORDS = 300;

  // Kinds of damage applied to a random stream
  typedef enum int {
    FLT_NONE,
    FLT_ODD,
    FLT_TRUNC,
    FLT_BAD_PAIR,
    FLT_LONE_LOW,
    FLT_NOISE
  } stream_fault_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  u16u8_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  u16u8_pkg::out_item_t out_data;

  utf16be_to_utf8_transcoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Transcoder model state
  logic [7:0] hi_byte;
  bit         hi_held;
  logic [9:0] surr_bits;
  bit         surr_waiting;
  bit         dropping;

  u16u8_pkg::out_item_t utf8_expected[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;   // no idling on either side while set
  bit          in_held = 1'b0;  // in_valid left high after the last accepted word

  // ---------------------------------------------------------------------------
  // Transcoder model
  // ---------------------------------------------------------------------------
  task automatic clear_stream();
    hi_byte      = '0;
    hi_held      = 1'b0;
    surr_bits    = '0;
    surr_waiting = 1'b0;
    dropping     = 1'b0;
  endtask

  task automatic push_word(logic [7:0] b, bit last, u16u8_pkg::err_code_t code);
    u16u8_pkg::out_item_t w;
    w.out_byte    = b;
    w.out_last    = last;
    w.error_code  = code;
    utf8_expected = {utf8_expected, w};
  endtask

  task automatic push_fault(u16u8_pkg::err_code_t code, bit at_end);
    clear_stream();
    dropping = !at_end;
    push_word(8'h00, 1'b1, code);
  endtask

  task automatic push_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      push_word(cp[7:0], 1'b1, u16u8_pkg::ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      push_word(8'hC0 | {3'b000, cp[10:6]}, 1'b0, u16u8_pkg::ERR_NONE);
      push_word({2'b10, cp[5:0]}, 1'b1, u16u8_pkg::ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      push_word(8'hE0 | {4'b0000, cp[15:12]}, 1'b0, u16u8_pkg::ERR_NONE);
      push_word({2'b10, cp[11:6]}, 1'b0, u16u8_pkg::ERR_NONE);
      push_word({2'b10, cp[5:0]}, 1'b1, u16u8_pkg::ERR_NONE);
    end else begin
      push_word(8'hF0 | {5'b00000, cp[20:18]}, 1'b0, u16u8_pkg::ERR_NONE);
      push_word({2'b10, cp[17:12]}, 1'b0, u16u8_pkg::ERR_NONE);
      push_word({2'b10, cp[11:6]}, 1'b0, u16u8_pkg::ERR_NONE);
      push_word({2'b10, cp[5:0]}, 1'b1, u16u8_pkg::ERR_NONE);
    end
  endtask

  // One accepted input byte in, zero to four expected words out
  task automatic predict_utf8(logic [7:0] b, bit eod);
    logic [15:0] unit;
    if (dropping) begin
      if (eod) clear_stream();
      return;
    end
    if (!hi_held) begin
      if (eod) begin
        push_fault(u16u8_pkg::ERR_ODD_LEN, 1'b1);
        return;
      end
      hi_byte = b;
      hi_held = 1'b1;
      return;
    end
    unit    = {hi_byte, b};
    hi_held = 1'b0;
    hi_byte = '0;
    if (surr_waiting) begin
      if (unit < 16'hDC00 || unit > 16'hDFFF) begin
        push_fault(u16u8_pkg::ERR_BAD_PAIR, eod);
        return;
      end
      push_code_point(21'h10000 + 21'({surr_bits, unit[9:0]}));
      surr_bits    = '0;
      surr_waiting = 1'b0;
    end else if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
      if (eod) begin
        push_fault(u16u8_pkg::ERR_TRUNC_PAIR, 1'b1);
        return;
      end
      surr_bits    = unit[9:0];
      surr_waiting = 1'b1;
      return;
    end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
      push_fault(u16u8_pkg::ERR_LONE_LOW, eod);
      return;
    end else begin
      push_code_point({5'b0, unit});
    end
    if (eod) clear_stream();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_bmp();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, 'h7F));
      1: return 16'($urandom_range('h80, 'h7FF));
      default: return ($urandom_range(0, 1) == 0) ? 16'($urandom_range('h800, 'hD7FF))
                                                  : 16'($urandom_range('hE000, 'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'(16'hD800 + $urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'(16'hDC00 + $urandom_range(0, 1023));
  endfunction

  // Send one word; in_valid stays high afterwards unless the next word idles first
  task automatic send_word(logic [7:0] b, bit eod);
    int unsigned         gap;
    u16u8_pkg::in_item_t w;
    gap           = steady ? 0 : pick_gap();
    w.in_byte     = b;
    w.end_of_data = eod;
    if (gap != 0) begin
      if (in_held) in_valid <= 1'b0;
      in_held = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    in_held   = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_utf8(b, eod);
    words_sent++;
  endtask

  task automatic send_unit(logic [15:0] unit, bit eod);
    send_word(unit[15:8], 1'b0);
    send_word(unit[7:0], eod);
  endtask

  // Drop in_valid in the step of the last acceptance, before any wait
  task automatic release_input();
    if (in_held) in_valid <= 1'b0;
    in_held = 1'b0;
  endtask

  task automatic wait_for_drain();
    release_input();
    while (utf8_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random stream of code points, optionally damaged, end mark on the last byte
  task automatic send_stream(int unsigned n_tok, stream_fault_t fault);
    logic [15:0] units[$];
    logic [7:0]  bytes[$];
    int unsigned at;
    at = $urandom_range(0, n_tok);
    for (int unsigned t = 0; t <= n_tok; t++) begin
      if (t == at) begin
        case (fault)
          FLT_BAD_PAIR: begin
            units = {units, rand_high()};
            units = {units, ($urandom_range(0, 3) == 0) ? rand_high() : rand_bmp()};
          end
          FLT_LONE_LOW: units = {units, rand_low()};
          default: ;
        endcase
      end
      if (t < n_tok) begin
        if ($urandom_range(0, 3) == 0) begin
          units = {units, rand_high()};
          units = {units, rand_low()};
        end else begin
          units = {units, rand_bmp()};
        end
      end
    end
    if (fault == FLT_TRUNC) units = {units, rand_high()};
    foreach (units[i]) begin
      bytes = {bytes, units[i][15:8]};
      bytes = {bytes, units[i][7:0]};
    end
    if (fault == FLT_ODD) bytes = {bytes, 8'($urandom_range(0, 255))};
    if (fault == FLT_NOISE) begin
      bytes.delete();
      repeat ($urandom_range(1, 12)) bytes = {bytes, 8'($urandom_range(0, 255))};
    end
    foreach (bytes[i]) send_word(bytes[i], i == bytes.size() - 1);
  endtask

  function automatic stream_fault_t pick_fault();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return FLT_NONE;
    if (r < 72) return FLT_ODD;
    if (r < 79) return FLT_TRUNC;
    if (r < 86) return FLT_BAD_PAIR;
    if (r < 93) return FLT_LONE_LOW;
    return FLT_NOISE;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Range edges of one-, two- and three-byte code points
  task automatic test_bmp_ranges();
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'hFFFF, 1'b1);
  endtask

  // Lowest and highest supplementary code points
  task automatic test_surrogate_pairs();
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
  endtask

  task automatic test_stream_faults();
    // odd length, plain and with a high surrogate waiting
    send_word(8'h41, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_word(8'h00, 1'b1);
    // high surrogate cut off by the end mark
    send_unit(16'hDBFF, 1'b1);
    // high surrogate followed by a non-low unit, then a dropped byte
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_word(8'hFF, 1'b1);
    // low surrogate with nothing waiting, on the end mark
    send_unit(16'hDC00, 1'b1);
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (8) send_stream($urandom_range(1, 6), pick_fault());
    steady = 1'b0;
  endtask

  // Sender holds off until every expected word is out
  task automatic test_drain_pause();
    send_stream($urandom_range(2, 6), FLT_NONE);
    wait_for_drain();
    send_stream($urandom_range(1, 4), pick_fault());
  endtask

  task automatic test_random_streams();
    int unsigned target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      send_stream($urandom_range(1, 6), pick_fault());
      if ($urandom_range(0, 39) == 0) wait_for_drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls and checking
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall = steady ? 0 : pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    u16u8_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (utf8_expected.size() == 0) begin
        $display("%0t: unexpected word byte %02h last %0b err %0d", $time,
                 out_data.out_byte, out_data.out_last, out_data.error_code);
        mismatches++;
      end else begin
        want = utf8_expected.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last ||
            out_data.error_code !== want.error_code) begin
          $display("%0t: expected byte %02h last %0b err %0d, got byte %02h last %0b err %0d",
                   $time, want.out_byte, want.out_last, want.error_code,
                   out_data.out_byte, out_data.out_last, out_data.error_code);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_utf16be_to_utf8_transcoder: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_stream();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bmp_ranges();
    test_surrogate_pairs();
    test_stream_faults();
    test_back_to_back();
    test_drain_pause();
    test_random_streams();

    wait_for_drain();
    if (mismatches == 0 && utf8_expected.size() == 0) begin
      $display("tb_utf16be_to_utf8_transcoder: clean");
    end else begin
      $display("tb_utf16be_to_utf8_transcoder: errors");
    end
    $finish;
  end

endmodule
